// ===== rtl/core/teq_pkg.sv =====
package teq_pkg;

   localparam int CAPACITY_DEF = 64;
   localparam int TIME_WIDTH   = 32;
   localparam int TAG_WIDTH    = 16;
   localparam int ID_WIDTH     = 16;

   localparam logic [1:0] OP_SCHEDULE = 2'd0;
   localparam logic [1:0] OP_REMOVE   = 2'd1;
   localparam logic [1:0] OP_ADVANCE  = 2'd2;
   localparam logic [1:0] OP_FORGET   = 2'd3;

   localparam logic [1:0] KIND_SCHED = 2'd0;
   localparam logic [1:0] KIND_REMOVE = 2'd1;
   localparam logic [1:0] KIND_FIRE  = 2'd2;

   typedef struct packed {
      logic [1:0]            op;
      logic [TIME_WIDTH-1:0] event_time;
      logic [TAG_WIDTH-1:0]  event_tag;
      logic [ID_WIDTH-1:0]   event_id;
      logic [TIME_WIDTH-1:0] position;
   } req_type;

   typedef struct packed {
      logic [1:0]            kind;
      logic                  ok;
      logic [ID_WIDTH-1:0]   out_id;
      logic [TAG_WIDTH-1:0]  out_tag;
      logic [TIME_WIDTH-1:0] out_time;
      logic                  last;
   } rsp_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_INSERT,
      ST_REMOVE,
      ST_ADVANCE,
      ST_ANSWER
   } state_type;

endpackage

// ===== rtl/core/teq_mem.sv =====
module teq_mem #(
   parameter int DEPTH = 64,
   parameter int WIDTH = 64
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data <= mem[rd_addr];
   end
endmodule

// ===== rtl/core/timed_event_queue_unit.sv =====
// Per item, n = events held (at most CAPACITY): schedule moves up the k events not earlier
// than the new time, or is refused unscanned when the table is full; remove and advance
// scan all n; forget gives no answer. One entry per cycle over one RAM port while no fired
// event waits. One item at a time: req_stall is high until the unit is idle again; the final
// answer and each fired event wait while the output register is held by rsp_stall.
// Synchronous active-high reset empties the table, clears the last position and the id count.
module timed_event_queue_unit #(
   parameter int CAPACITY = teq_pkg::CAPACITY_DEF
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  teq_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output teq_pkg::rsp_type rsp_data
);
   import teq_pkg::*;

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int EW = TIME_WIDTH + TAG_WIDTH + ID_WIDTH;

   state_type state_ff, state_in;
   req_type   req_ff, req_in;
   logic [CW-1:0]         cnt_ff, cnt_in;     // entries held
   logic [CW-1:0]         idx_ff, idx_in;     // scan pointer / insert hole
   logic                  found_ff, found_in;
   logic [EW-1:0]         hold_ff, hold_in;   // pending fired entry
   logic [TIME_WIDTH-1:0] lpos_ff, lpos_in;
   logic                  lknown_ff, lknown_in;
   logic [ID_WIDTH-1:0]   idc_ff, idc_in;
   logic                  ovld_ff, ovld_in;
   rsp_type               out_ff, out_in;

   logic          wr_en;
   logic [AW-1:0] wr_addr, rd_addr;
   logic [EW-1:0] wr_data, rd_data;

   logic [TIME_WIDTH-1:0] rd_time, hold_time;
   logic [TAG_WIDTH-1:0]  hold_tag;
   logic [ID_WIDTH-1:0]   rd_id, hold_id;
   logic [EW-1:0]         new_entry;
   logic                  accept, out_free, at_end, ins_stop, fire, adv_wait;

   teq_mem #(.DEPTH(CAPACITY), .WIDTH(EW)) u_mem (
      .clock(clock), .wr_en(wr_en), .wr_addr(wr_addr), .wr_data(wr_data),
      .rd_addr(rd_addr), .rd_data(rd_data)
   );

   assign rd_time   = rd_data[EW-1 -: TIME_WIDTH];
   assign rd_id     = rd_data[ID_WIDTH-1:0];
   assign hold_time = hold_ff[EW-1 -: TIME_WIDTH];
   assign hold_tag  = hold_ff[ID_WIDTH +: TAG_WIDTH];
   assign hold_id   = hold_ff[ID_WIDTH-1:0];
   assign new_entry = {req_ff.event_time, req_ff.event_tag, idc_ff};

   assign accept   = req_valid && !req_stall;
   assign out_free = !ovld_ff || !rsp_stall;
   assign at_end   = (idx_ff == cnt_ff);
   // insert walks down from the top; rd_data holds the entry just below the hole
   assign ins_stop = (idx_ff == '0) || (rd_time < req_ff.event_time);
   assign fire     = lknown_ff ? (rd_time > lpos_ff && rd_time <= req_ff.position)
                               : (rd_time == req_ff.position);
   // a new fire has to wait while the previous one cannot be handed over
   assign adv_wait = fire && found_ff && !out_free;

   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = ovld_ff;
   assign rsp_data  = out_ff;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               unique case (req_data.op)
                  OP_SCHEDULE: state_in = (cnt_ff == CW'(CAPACITY)) ? ST_ANSWER : ST_INSERT;
                  OP_REMOVE:   state_in = ST_REMOVE;
                  OP_ADVANCE:  state_in = ST_ADVANCE;
                  OP_FORGET:   state_in = ST_IDLE;
               endcase
            end
         end
         ST_INSERT: if (ins_stop) state_in = ST_ANSWER;
         ST_REMOVE: if (at_end) state_in = ST_ANSWER;
         ST_ADVANCE: if (at_end) state_in = found_ff ? ST_ANSWER : ST_IDLE;
         ST_ANSWER: if (out_free) state_in = ST_IDLE;
         default: state_in = ST_IDLE;
      endcase
   end

   always_comb begin
      req_in    = req_ff;
      cnt_in    = cnt_ff;
      idx_in    = idx_ff;
      found_in  = found_ff;
      hold_in   = hold_ff;
      lpos_in   = lpos_ff;
      lknown_in = lknown_ff;
      idc_in    = idc_ff;
      ovld_in   = ovld_ff && rsp_stall;
      out_in    = out_ff;
      wr_en     = 1'b0;
      wr_addr   = AW'(idx_ff);
      wr_data   = rd_data;
      rd_addr   = AW'(idx_ff);
      unique case (state_ff)
         ST_IDLE: begin
            if (accept) begin
               req_in   = req_data;
               found_in = 1'b0;
               unique case (req_data.op)
                  OP_SCHEDULE: begin
                     idx_in  = cnt_ff;
                     rd_addr = AW'(cnt_ff - CW'(1));
                  end
                  OP_FORGET: lknown_in = 1'b0;
                  default: begin
                     idx_in  = '0;
                     rd_addr = '0;
                  end
               endcase
            end
         end
         ST_INSERT: begin
            wr_en   = 1'b1;
            wr_addr = AW'(idx_ff);
            if (ins_stop) begin
               wr_data  = new_entry;
               found_in = 1'b1;
            end else begin
               wr_data = rd_data;
               idx_in  = idx_ff - CW'(1);
               rd_addr = AW'(idx_ff - CW'(2));
            end
         end
         ST_REMOVE: begin
            if (!at_end) begin
               if (found_ff) begin
                  // close the gap: move entry idx down by one
                  wr_en   = 1'b1;
                  wr_addr = AW'(idx_ff - CW'(1));
                  wr_data = rd_data;
               end else if (rd_id == req_ff.event_id) begin
                  found_in = 1'b1;
               end
               idx_in  = idx_ff + CW'(1);
               rd_addr = AW'(idx_ff + CW'(1));
            end
         end
         ST_ADVANCE: begin
            if (at_end) begin
               lpos_in   = req_ff.position;
               lknown_in = 1'b1;
            end else if (!adv_wait) begin
               if (fire) begin
                  if (found_ff) begin
                     ovld_in = 1'b1;
                     out_in  = '{kind: KIND_FIRE, ok: 1'b1, out_id: hold_id,
                                 out_tag: hold_tag, out_time: hold_time, last: 1'b0};
                  end
                  hold_in  = rd_data;
                  found_in = 1'b1;
               end
               idx_in  = idx_ff + CW'(1);
               rd_addr = AW'(idx_ff + CW'(1));
            end
         end
         ST_ANSWER: begin
            if (out_free) begin
               ovld_in = 1'b1;
               unique case (req_ff.op)
                  OP_SCHEDULE: begin
                     out_in = '{kind: KIND_SCHED, ok: found_ff,
                                out_id: found_ff ? idc_ff : '0,
                                out_tag: '0, out_time: '0, last: 1'b1};
                     if (found_ff) begin
                        cnt_in = cnt_ff + CW'(1);
                        idc_in = idc_ff + ID_WIDTH'(1);
                     end
                  end
                  OP_REMOVE: begin
                     out_in = '{kind: KIND_REMOVE, ok: found_ff, out_id: req_ff.event_id,
                                out_tag: '0, out_time: '0, last: 1'b1};
                     if (found_ff) cnt_in = cnt_ff - CW'(1);
                  end
                  default: begin
                     out_in = '{kind: KIND_FIRE, ok: 1'b1, out_id: hold_id,
                                out_tag: hold_tag, out_time: hold_time, last: 1'b1};
                  end
               endcase
            end
         end
         default: ;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= ST_IDLE;
         req_ff    <= '0;
         cnt_ff    <= '0;
         idx_ff    <= '0;
         found_ff  <= 1'b0;
         hold_ff   <= '0;
         lpos_ff   <= '0;
         lknown_ff <= 1'b0;
         idc_ff    <= '0;
         ovld_ff   <= 1'b0;
         out_ff    <= '0;
      end else begin
         state_ff  <= state_in;
         req_ff    <= req_in;
         cnt_ff    <= cnt_in;
         idx_ff    <= idx_in;
         found_ff  <= found_in;
         hold_ff   <= hold_in;
         lpos_ff   <= lpos_in;
         lknown_ff <= lknown_in;
         idc_ff    <= idc_in;
         ovld_ff   <= ovld_in;
         out_ff    <= out_in;
      end
   end
endmodule
